// File: src/gcst_pkg.sv
package gcst_pkg;

  // Operation codes of an incoming request.
  localparam logic [2:0] OP_STATUS_ENTRY = 3'd0;
  localparam logic [2:0] OP_EMPTY_ARRAY  = 3'd1;
  localparam logic [2:0] OP_RESULT       = 3'd2;
  localparam logic [2:0] OP_FEEDBACK     = 3'd3;
  localparam logic [2:0] OP_SET_STATE    = 3'd4;

  // Communication states.
  localparam logic [2:0] ST_WAIT_ACK    = 3'd0;
  localparam logic [2:0] ST_WAIT_RESULT = 3'd3;
  localparam logic [2:0] ST_WAIT_CANCEL = 3'd4;
  localparam logic [2:0] ST_DONE        = 3'd7;

  // Remote goal status codes.
  localparam logic [3:0] STATUS_LOST      = 4'd9;
  localparam logic [3:0] STATUS_LAST_KNOWN = 4'd9;

  // Error codes.
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_INVALID     = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN     = 2'd2;
  localparam logic [1:0] ERR_RESULT_DONE = 2'd3;

  // Transition table entries: 0..7 is the next state, the rest are actions.
  localparam logic [3:0] ACT_STAY = 4'd8;
  localparam logic [3:0] ACT_INV  = 4'd9;
  localparam logic [3:0] ACT_UNK  = 4'd10;

  localparam logic [3:0] NEXT_TAB [8][10] = '{
    '{4'd1, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd6, 4'd5, 4'd3, ACT_UNK},
    '{ACT_STAY, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd6, 4'd5, 4'd3, ACT_UNK},
    '{ACT_INV, ACT_STAY, 4'd3, 4'd3, 4'd3, ACT_INV, 4'd6, ACT_INV, ACT_INV, ACT_UNK},
    '{ACT_INV, ACT_STAY, ACT_STAY, ACT_STAY, ACT_STAY, ACT_STAY, ACT_INV, ACT_INV,
      ACT_STAY, ACT_UNK},
    '{ACT_STAY, ACT_STAY, 4'd3, 4'd3, 4'd3, 4'd3, 4'd6, 4'd5, 4'd3, ACT_UNK},
    '{ACT_INV, ACT_INV, 4'd3, 4'd3, 4'd3, 4'd3, 4'd6, ACT_STAY, 4'd3, ACT_UNK},
    '{ACT_INV, ACT_INV, 4'd3, 4'd3, 4'd3, ACT_INV, ACT_STAY, ACT_INV, ACT_INV, ACT_UNK},
    '{ACT_INV, ACT_INV, ACT_STAY, ACT_STAY, ACT_STAY, ACT_STAY, ACT_INV, ACT_INV,
      ACT_STAY, ACT_UNK}
  };

  // Work kinds handed from the front to the back.
  typedef enum logic [2:0] {
    CMD_NOP      = 3'd0,
    CMD_APPLY    = 3'd1,
    CMD_RESULT   = 3'd2,
    CMD_FEEDBACK = 3'd3,
    CMD_SET      = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       found;
    logic [3:0] status;
    logic [2:0] new_state;
  } cmd_t;

  typedef struct packed {
    logic [2:0] comm_state;
    logic [3:0] latest_status;
    logic       transitioned;
    logic       feedback_forward;
    logic [1:0] error_code;
  } res_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

endpackage

// File: src/gcst_queue.sv
module gcst_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// File: src/gcst_front.sv
module gcst_front #(
  parameter int GOAL_ID_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [63:0]         cfg_wdata,
  input  logic                accept,
  input  logic [2:0]          operation,
  input  logic [63:0]         msg_goal_id,
  input  logic [3:0]          remote_status,
  input  logic                last_entry,
  input  logic [2:0]          new_state,
  output gcst_pkg::cmd_t      cmd
);

  logic [GOAL_ID_BITS-1:0] own_id;
  logic                    match_found;
  logic [3:0]              matched_status;
  logic                    id_match;
  logic                    take_entry;

  assign id_match   = (msg_goal_id[GOAL_ID_BITS-1:0] == own_id);
  // Only the first matching entry of an array is remembered.
  assign take_entry = (operation == gcst_pkg::OP_STATUS_ENTRY) && !match_found && id_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= '0;
    end else if (cfg_we) begin
      own_id <= cfg_wdata[GOAL_ID_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_found    <= 1'b0;
      matched_status <= '0;
    end else if (accept) begin
      if ((operation == gcst_pkg::OP_STATUS_ENTRY && last_entry) ||
          operation == gcst_pkg::OP_EMPTY_ARRAY) begin
        match_found    <= 1'b0;
        matched_status <= '0;
      end else if (take_entry) begin
        match_found    <= 1'b1;
        matched_status <= remote_status;
      end
    end
  end

  always_comb begin
    cmd.kind      = gcst_pkg::CMD_NOP;
    cmd.found     = 1'b0;
    cmd.status    = remote_status;
    cmd.new_state = new_state;
    case (operation)
      gcst_pkg::OP_STATUS_ENTRY: begin
        if (last_entry) begin
          cmd.kind   = gcst_pkg::CMD_APPLY;
          cmd.found  = match_found || take_entry;
          cmd.status = match_found ? matched_status : remote_status;
        end
      end
      gcst_pkg::OP_EMPTY_ARRAY: begin
        cmd.kind = gcst_pkg::CMD_APPLY;
      end
      gcst_pkg::OP_RESULT: begin
        if (id_match) begin
          cmd.kind = gcst_pkg::CMD_RESULT;
        end
      end
      gcst_pkg::OP_FEEDBACK: begin
        if (id_match) begin
          cmd.kind = gcst_pkg::CMD_FEEDBACK;
        end
      end
      gcst_pkg::OP_SET_STATE: begin
        cmd.kind = gcst_pkg::CMD_SET;
      end
      default: begin
        cmd.kind = gcst_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

// File: src/gcst_back.sv
module gcst_back (
  input  logic           clk,
  input  logic           rst,
  input  gcst_pkg::cmd_t cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output gcst_pkg::res_t res
);

  logic [2:0] state;
  logic [2:0] state_next;
  logic [3:0] recorded_status;
  logic [3:0] recorded_status_next;
  logic [3:0] action;
  logic       tr;
  logic       fwd;
  logic [1:0] err;

  assign cmd_pop  = !cmd_empty && !res_full;
  assign res_push = cmd_pop;

  always_comb begin
    action = (cmd.status <= gcst_pkg::STATUS_LAST_KNOWN) ?
             gcst_pkg::NEXT_TAB[state][cmd.status] : gcst_pkg::ACT_UNK;
  end

  always_comb begin
    state_next           = state;
    recorded_status_next = recorded_status;
    tr                   = 1'b0;
    fwd                  = 1'b0;
    err                  = gcst_pkg::ERR_NONE;
    unique case (cmd.kind)
      gcst_pkg::CMD_APPLY: begin
        if (!cmd.found) begin
          // No entry for this goal: it is lost unless the state is waiting for ack, waiting for the result or done.
          if (state != gcst_pkg::ST_WAIT_ACK && state != gcst_pkg::ST_WAIT_RESULT &&
              state != gcst_pkg::ST_DONE) begin
            recorded_status_next = gcst_pkg::STATUS_LOST;
            state_next           = gcst_pkg::ST_DONE;
            tr                   = 1'b1;
          end
        end else begin
          recorded_status_next = cmd.status;
          if (action == gcst_pkg::ACT_INV) begin
            err = gcst_pkg::ERR_INVALID;
          end else if (action == gcst_pkg::ACT_UNK) begin
            err = gcst_pkg::ERR_UNKNOWN;
          end else if (action != gcst_pkg::ACT_STAY) begin
            state_next = action[2:0];
            tr         = 1'b1;
          end
        end
      end
      gcst_pkg::CMD_RESULT: begin
        recorded_status_next = cmd.status;
        if (state == gcst_pkg::ST_DONE) begin
          err = gcst_pkg::ERR_RESULT_DONE;
        end else if (state == gcst_pkg::ST_WAIT_CANCEL) begin
          err = gcst_pkg::ERR_UNKNOWN;
        end else begin
          state_next = gcst_pkg::ST_DONE;
          tr         = 1'b1;
        end
      end
      gcst_pkg::CMD_FEEDBACK: begin
        fwd = 1'b1;
      end
      gcst_pkg::CMD_SET: begin
        state_next = cmd.new_state;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= gcst_pkg::ST_WAIT_ACK;
      recorded_status <= '0;
    end else if (cmd_pop) begin
      state           <= state_next;
      recorded_status <= recorded_status_next;
    end
  end

  always_comb begin
    res.comm_state       = state_next;
    res.latest_status    = recorded_status_next;
    res.transitioned     = tr;
    res.feedback_forward = fwd;
    res.error_code       = err;
  end

  a_err_no_transition: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.error_code != gcst_pkg::ERR_NONE) |-> !res.transitioned)
    else $error("error result also reports a transition");

  a_fwd_clean: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.feedback_forward) |->
      (!res.transitioned && res.error_code == gcst_pkg::ERR_NONE && res.comm_state == state))
    else $error("forwarded feedback carries other effects");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !cmd_pop |=> $stable(state) && $stable(recorded_status))
    else $error("tracker state changed without a request");

  a_lost_done: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.transitioned && res.latest_status == gcst_pkg::STATUS_LOST &&
     cmd.kind == gcst_pkg::CMD_APPLY && !cmd.found) |-> res.comm_state == gcst_pkg::ST_DONE)
    else $error("lost goal did not finish");

endmodule

// File: src/goal_comm_state_tracker_top.sv
// Throughput: one request per cycle while full is low and the result queue does not stall the back;
// the front classifies a request into a two-entry command queue, and the back takes its head,
// updates the state and writes a two-entry result queue, whose head drives the result ports.
// A full result queue stalls the back, and a full command queue raises full.
// Reset (rst, synchronous, active high) empties both queues, sets the state to waiting for
// ack, clears the recorded status, any partial status array match, and own_goal_id.
module goal_comm_state_tracker_top #(
  parameter int GOAL_ID_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [63:0] msg_goal_id,
  input  logic [3:0]  remote_status,
  input  logic        last_entry,
  input  logic [2:0]  new_state,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  comm_state,
  output logic [3:0]  latest_status,
  output logic        transitioned,
  output logic        feedback_forward,
  output logic [1:0]  error_code
);

  gcst_pkg::cmd_t              front_cmd;
  gcst_pkg::cmd_t              back_cmd;
  gcst_pkg::res_t              back_res;
  gcst_pkg::res_t              out_res;
  logic [gcst_pkg::CMD_W-1:0]  cmd_head;
  logic [gcst_pkg::RES_W-1:0]  res_head;
  logic                        accept;
  logic                        cmd_empty;
  logic                        cmd_pop;
  logic                        res_full;
  logic                        res_push;

  assign accept   = push && !full;
  assign back_cmd = gcst_pkg::cmd_t'(cmd_head);
  assign out_res  = gcst_pkg::res_t'(res_head);

  gcst_front #(
    .GOAL_ID_BITS(GOAL_ID_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .operation    (operation),
    .msg_goal_id  (msg_goal_id),
    .remote_status(remote_status),
    .last_entry   (last_entry),
    .new_state    (new_state),
    .cmd          (front_cmd)
  );

  gcst_queue #(
    .WIDTH(gcst_pkg::CMD_W),
    .DEPTH(2)
  ) u_cmd_queue (
    .clk  (clk),
    .rst  (rst),
    .push (accept),
    .din  (front_cmd),
    .full (full),
    .pop  (cmd_pop),
    .dout (cmd_head),
    .empty(cmd_empty)
  );

  gcst_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (back_cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res)
  );

  gcst_queue #(
    .WIDTH(gcst_pkg::RES_W),
    .DEPTH(2)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (back_res),
    .full (res_full),
    .pop  (pop),
    .dout (res_head),
    .empty(empty)
  );

  assign comm_state       = out_res.comm_state;
  assign latest_status    = out_res.latest_status;
  assign transitioned     = out_res.transitioned;
  assign feedback_forward = out_res.feedback_forward;
  assign error_code       = out_res.error_code;

endmodule

// File: tb/goal_comm_state_tracker_top_tb.sv
`timescale 1ns / 1ps

module goal_comm_state_tracker_top_tb;

  localparam int ID_BITS = 64;
  localparam logic [63:0] ID_MASK = {64{1'b1}} >> (64 - ID_BITS);
  localparam logic [63:0] ID_ONES = {64{1'b1}};
  localparam logic [63:0] ID_ZERO = 64'd0;
  localparam int CLK_HALF = 5;
  localparam int MAX_WAIT = 13;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 4;
  localparam int MAX_REPORTS = 10;

  localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

  localparam logic [2:0] ST_PENDING    = 3'd1;
  localparam logic [2:0] ST_ACTIVE     = 3'd2;
  localparam logic [2:0] ST_RECALLING  = 3'd5;
  localparam logic [2:0] ST_PREEMPTING = 3'd6;

  localparam logic [3:0] STS_PENDING    = 4'd0;
  localparam logic [3:0] STS_ACTIVE     = 4'd1;
  localparam logic [3:0] STS_SUCCEEDED  = 4'd3;
  localparam logic [3:0] STS_ABORTED    = 4'd4;
  localparam logic [3:0] STS_PREEMPTING = 4'd6;
  localparam logic [3:0] STS_RECALLING  = 4'd7;
  localparam logic [3:0] STS_RECALLED   = 4'd8;
  localparam logic [3:0] STS_TOP        = 4'd15;

  // Next-state entries of the goal transition table, widened to the action width.
  localparam logic [3:0] TO_PEN = {1'b0, ST_PENDING};
  localparam logic [3:0] TO_ACT = {1'b0, ST_ACTIVE};
  localparam logic [3:0] TO_WR  = {1'b0, gcst_pkg::ST_WAIT_RESULT};
  localparam logic [3:0] TO_REC = {1'b0, ST_RECALLING};
  localparam logic [3:0] TO_PRE = {1'b0, ST_PREEMPTING};
  localparam logic [3:0] STAY   = gcst_pkg::ACT_STAY;
  localparam logic [3:0] INV    = gcst_pkg::ACT_INV;
  localparam logic [3:0] UNK    = gcst_pkg::ACT_UNK;

  // Rows are communication states, columns are remote status codes pending through lost.
  localparam logic [3:0] GOAL_NEXT [8][10] = '{
    '{TO_PEN, TO_ACT, TO_WR, TO_WR, TO_WR, TO_WR, TO_PRE, TO_REC, TO_WR, UNK},
    '{STAY,   TO_ACT, TO_WR, TO_WR, TO_WR, TO_WR, TO_PRE, TO_REC, TO_WR, UNK},
    '{INV,    STAY,   TO_WR, TO_WR, TO_WR, INV,   TO_PRE, INV,    INV,   UNK},
    '{INV,    STAY,   STAY,  STAY,  STAY,  STAY,  INV,    INV,    STAY,  UNK},
    '{STAY,   STAY,   TO_WR, TO_WR, TO_WR, TO_WR, TO_PRE, TO_REC, TO_WR, UNK},
    '{INV,    INV,    TO_WR, TO_WR, TO_WR, TO_WR, TO_PRE, STAY,   TO_WR, UNK},
    '{INV,    INV,    TO_WR, TO_WR, TO_WR, INV,   STAY,   INV,    INV,   UNK},
    '{INV,    INV,    STAY,  STAY,  STAY,  STAY,  INV,    INV,    STAY,  UNK}
  };

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] gid;
    logic [3:0]  rs;
    logic        last;
    logic [2:0]  ns;
  } req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  operation = '0;
  logic [63:0] msg_goal_id = '0;
  logic [3:0]  remote_status = '0;
  logic        last_entry = 1'b0;
  logic [2:0]  new_state = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  comm_state;
  logic [3:0]  latest_status;
  logic        transitioned;
  logic        feedback_forward;
  logic [1:0]  error_code;

  // Predicted tracker state.
  logic [63:0]    own_id = '0;
  logic [2:0]     trk_state = gcst_pkg::ST_WAIT_ACK;
  logic [3:0]     trk_status = '0;
  logic           arr_hit = 1'b0;
  logic [3:0]     arr_status = '0;
  gcst_pkg::res_t tracker_outcomes[$];

  int fail_count = 0;
  int requests_sent = 0;
  int pop_stall = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  goal_comm_state_tracker_top #(.GOAL_ID_BITS(ID_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .push(push),
    .full(full),
    .operation(operation),
    .msg_goal_id(msg_goal_id),
    .remote_status(remote_status),
    .last_entry(last_entry),
    .new_state(new_state),
    .empty(empty),
    .pop(pop),
    .comm_state(comm_state),
    .latest_status(latest_status),
    .transitioned(transitioned),
    .feedback_forward(feedback_forward),
    .error_code(error_code)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic goal_hit(logic [63:0] gid);
    return (gid & ID_MASK) == (own_id & ID_MASK);
  endfunction

  // Array end: a match steps the table, else lost unless WAIT_ACK, WAIT_RESULT or DONE.
  task automatic close_status_array(input logic found, input logic [3:0] sts,
                                    inout gcst_pkg::res_t o);
    logic [3:0] act;
    int col;
    col = int'(sts);
    if (!found) begin
      if (trk_state != gcst_pkg::ST_WAIT_ACK && trk_state != gcst_pkg::ST_WAIT_RESULT &&
          trk_state != gcst_pkg::ST_DONE) begin
        trk_status = gcst_pkg::STATUS_LOST;
        trk_state = gcst_pkg::ST_DONE;
        o.transitioned = 1'b1;
      end
    end else begin
      trk_status = sts;
      act = (sts <= gcst_pkg::STATUS_LAST_KNOWN) ? GOAL_NEXT[trk_state][col] :
            gcst_pkg::ACT_UNK;
      if (act == gcst_pkg::ACT_INV) o.error_code = gcst_pkg::ERR_INVALID;
      else if (act == gcst_pkg::ACT_UNK) o.error_code = gcst_pkg::ERR_UNKNOWN;
      else if (act != gcst_pkg::ACT_STAY) begin
        trk_state = act[2:0];
        o.transitioned = 1'b1;
      end
    end
  endtask

  task automatic track_goal_request(input req_t r);
    gcst_pkg::res_t o;
    o = '0;
    case (r.op)
      gcst_pkg::OP_STATUS_ENTRY: begin
        if (!arr_hit && goal_hit(r.gid)) begin
          arr_hit = 1'b1;
          arr_status = r.rs;
        end
        if (r.last) begin
          close_status_array(arr_hit, arr_status, o);
          arr_hit = 1'b0;
          arr_status = '0;
        end
      end
      gcst_pkg::OP_EMPTY_ARRAY: begin
        arr_hit = 1'b0;
        arr_status = '0;
        close_status_array(1'b0, '0, o);
      end
      gcst_pkg::OP_RESULT: begin
        if (goal_hit(r.gid)) begin
          trk_status = r.rs;
          if (trk_state == gcst_pkg::ST_DONE) o.error_code = gcst_pkg::ERR_RESULT_DONE;
          else if (trk_state == gcst_pkg::ST_WAIT_CANCEL) o.error_code = gcst_pkg::ERR_UNKNOWN;
          else begin
            trk_state = gcst_pkg::ST_DONE;
            o.transitioned = 1'b1;
          end
        end
      end
      gcst_pkg::OP_FEEDBACK: begin
        if (goal_hit(r.gid)) o.feedback_forward = 1'b1;
      end
      gcst_pkg::OP_SET_STATE: begin
        trk_state = r.ns;
      end
      default: begin
      end
    endcase
    o.comm_state = trk_state;
    o.latest_status = trk_status;
    tracker_outcomes.push_back(o);
  endtask

  function automatic string res_text(gcst_pkg::res_t v);
    return $sformatf("state %0d status %0d tr %0b fwd %0b err %0d", v.comm_state,
                     v.latest_status, v.transitioned, v.feedback_forward, v.error_code);
  endfunction

  task automatic note_failure(input string what, input gcst_pkg::res_t want,
                              input gcst_pkg::res_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t %s: expected %s, got %s", $time, what, res_text(want), res_text(got));
  endtask

  // Result side: compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    gcst_pkg::res_t want;
    gcst_pkg::res_t got;
    if (!rst && pop && !empty) begin
      got = '{comm_state, latest_status, transitioned, feedback_forward, error_code};
      if (tracker_outcomes.size() == 0) begin
        note_failure("result with no request outstanding", '0, got);
      end else begin
        want = tracker_outcomes.pop_front();
        if (got.comm_state !== want.comm_state || got.latest_status !== want.latest_status ||
            got.transitioned !== want.transitioned ||
            got.feedback_forward !== want.feedback_forward ||
            got.error_code !== want.error_code)
          note_failure("result mismatch", want, got);
      end
      pop_stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    end
  end

  always @(negedge clk) begin
    if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall = pop_stall - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[goal_comm_state_tracker_top] ERROR");
      $finish;
    end
  end

  function automatic req_t make_request(logic [2:0] op, logic [63:0] gid, logic [3:0] rs,
                                        logic last, logic [2:0] ns);
    req_t r;
    r.op = op;
    r.gid = gid;
    r.rs = rs;
    r.last = last;
    r.ns = ns;
    return r;
  endfunction

  function automatic req_t rand_req(logic [2:0] op);
    return make_request(op, {$urandom, $urandom}, 4'($urandom), 1'($urandom), 3'($urandom));
  endfunction

  // The push stays high into the next request when there is no gap, so it is never
  // lowered and raised within one step.
  task automatic send_request(input req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    operation <= r.op;
    msg_goal_id <= r.gid;
    remote_status <= r.rs;
    last_entry <= r.last;
    new_state <= r.ns;
    @(posedge clk);
    while (full) @(posedge clk);
    track_goal_request(r);
    requests_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    push <= 1'b0;
    while (tracker_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_goal_id(input logic [63:0] id);
    wait_for_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= id;
    @(negedge clk);
    cfg_we <= 1'b0;
    own_id = id;
  endtask

  function automatic logic [63:0] pick_goal_id();
    logic [63:0] id;
    case ($urandom_range(0, 3))
      0, 1: id = own_id;
      2: id = own_id ^ (64'd1 << $urandom_range(0, 63));
      default: id = {$urandom, $urandom};
    endcase
    return id;
  endfunction

  function automatic logic [3:0] pick_status();
    if ($urandom_range(0, 7) == 0)
      return 4'($urandom_range(int'(gcst_pkg::STATUS_LAST_KNOWN) + 1, int'(STS_TOP)));
    return 4'($urandom_range(0, int'(gcst_pkg::STATUS_LAST_KNOWN)));
  endfunction

  task automatic send_side_request();
    req_t r;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) r = rand_req(gcst_pkg::OP_RESULT);
    else if (pick < 7) r = rand_req(gcst_pkg::OP_FEEDBACK);
    else if (pick < 9) r = rand_req(gcst_pkg::OP_SET_STATE);
    else r = rand_req(3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST)));
    r.gid = pick_goal_id();
    send_request(r);
  endtask

  // A status array of one to four entries; now and then it is cut short and may be
  // followed by an empty array, which has to drop the partial match.
  task automatic send_status_array();
    req_t r;
    int len;
    bit cut;
    len = $urandom_range(1, 4);
    cut = ($urandom_range(0, 7) == 0);
    for (int k = 0; k < len; k++) begin
      r = rand_req(gcst_pkg::OP_STATUS_ENTRY);
      r.gid = pick_goal_id();
      r.rs = pick_status();
      r.last = (k == len - 1) && !cut;
      send_request(r);
      if (k < len - 1 && $urandom_range(0, 7) == 0) send_side_request();
    end
    if (cut && $urandom_range(0, 1) == 1) send_request(rand_req(gcst_pkg::OP_EMPTY_ARRAY));
  endtask

  task automatic run_random_requests(input int count);
    int first;
    int pick;
    first = requests_sent;
    while (requests_sent - first < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) send_status_array();
      else if (pick < 9) send_side_request();
      else send_request(rand_req(gcst_pkg::OP_EMPTY_ARRAY));
    end
  endtask

  task automatic test_directed_cases();
    write_goal_id(ID_ONES);
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ONES, STS_PENDING, 1'b1, '0));
    send_request(make_request(gcst_pkg::OP_FEEDBACK, ID_ONES, '0, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_FEEDBACK, ID_ZERO, '0, 1'b0, '0));
    // Only the first matching entry of an array counts.
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ZERO, STS_SUCCEEDED, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ONES, STS_ACTIVE, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ONES, STS_SUCCEEDED, 1'b1, '0));
    send_request(make_request(gcst_pkg::OP_EMPTY_ARRAY, ID_ONES, STS_TOP, 1'b1, '1));
    send_request(make_request(gcst_pkg::OP_RESULT, ID_ONES, STS_SUCCEEDED, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_SET_STATE, ID_ZERO, '0, 1'b0,
                              gcst_pkg::ST_WAIT_CANCEL));
    send_request(make_request(gcst_pkg::OP_RESULT, ID_ONES, STS_ABORTED, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_SET_STATE, ID_ZERO, '0, 1'b0, ST_ACTIVE));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ONES, STS_TOP, 1'b1, '0));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ONES, gcst_pkg::STATUS_LOST,
                              1'b1, '0));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ONES, STS_PENDING, 1'b1, '0));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ONES, STS_ACTIVE, 1'b1, '0));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ZERO, STS_ACTIVE, 1'b1, '0));
    // Arrays without a match leave waiting for ack and waiting for the result alone.
    send_request(make_request(gcst_pkg::OP_SET_STATE, ID_ZERO, '0, 1'b0,
                              gcst_pkg::ST_WAIT_ACK));
    send_request(make_request(gcst_pkg::OP_EMPTY_ARRAY, ID_ZERO, '0, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_SET_STATE, ID_ZERO, '0, 1'b0,
                              gcst_pkg::ST_WAIT_RESULT));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ZERO, STS_ACTIVE, 1'b1, '0));
    send_request(make_request(gcst_pkg::OP_SET_STATE, ID_ZERO, '0, 1'b0, ST_PREEMPTING));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ONES, STS_RECALLED, 1'b1, '0));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ONES, STS_PREEMPTING, 1'b1, '0));
    // Other requests between entries keep the partial match.
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ONES, STS_RECALLING, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_RESULT, ID_ZERO, STS_SUCCEEDED, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_FEEDBACK, ID_ONES, '0, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_SET_STATE, ID_ZERO, '0, 1'b0, ST_RECALLING));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ZERO, STS_PENDING, 1'b1, '0));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ONES, STS_SUCCEEDED, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_EMPTY_ARRAY, ID_ONES, '0, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_SET_STATE, ID_ZERO, '0, 1'b0, ST_PENDING));
    send_request(make_request(gcst_pkg::OP_RESULT, ID_ONES, STS_SUCCEEDED, 1'b0, '0));
    for (int op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST; op++)
      send_request(make_request(3'(op), ID_ONES, STS_TOP, 1'b1, '1));
  endtask

  task automatic test_goal_id_settings();
    write_goal_id(ID_ZERO);
    send_request(make_request(gcst_pkg::OP_SET_STATE, ID_ONES, '0, 1'b0,
                              gcst_pkg::ST_WAIT_ACK));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ZERO, STS_PENDING, 1'b1, '0));
    send_request(make_request(gcst_pkg::OP_STATUS_ENTRY, ID_ONES, STS_ACTIVE, 1'b1, '0));
    send_request(make_request(gcst_pkg::OP_FEEDBACK, ID_ZERO, '0, 1'b0, '0));
    write_goal_id({1'b1, 62'd0, 1'b1});
    send_request(make_request(gcst_pkg::OP_FEEDBACK, 64'd1, '0, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_FEEDBACK, {1'b1, 62'd0, 1'b1}, '0, 1'b0, '0));
    send_request(make_request(gcst_pkg::OP_RESULT, {1'b1, 62'd0, 1'b1}, STS_RECALLED,
                              1'b0, '0));
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_goal_id(ID_ZERO);
        1: write_goal_id(ID_ONES);
        default: write_goal_id({$urandom, $urandom});
      endcase
      // One phase runs back to back on both sides.
      no_idle = (p == 3);
      run_random_requests(80);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_hold_until_drained();
    run_random_requests(20);
    wait_for_results();
    run_random_requests(20);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_goal_id_settings();
    test_random_traffic();
    test_hold_until_drained();
    wait_for_results();
    if (fail_count == 0) begin
      $display("[goal_comm_state_tracker_top] OK");
    end else begin
      $display("[goal_comm_state_tracker_top] ERROR");
    end
    $finish;
  end

endmodule
